FILE: rtl/necir_pkg.sv
package necir_pkg;

	// Pulse timing of the NEC format, microseconds
	localparam logic [15:0] LEAD_MARK  = 16'd9000;
	localparam logic [15:0] LEAD_SPACE = 16'd4500;
	localparam logic [15:0] BIT_MARK   = 16'd560;
	localparam logic [15:0] ZERO_SPACE = 16'd560;
	localparam logic [15:0] ONE_SPACE  = 16'd1690;
	localparam logic [15:0] REP_MARK   = 16'd9000;
	localparam logic [15:0] REP_SPACE  = 16'd2250;

	// Burst layout: leader, 16 address bits, 16 command bits, stop symbol
	localparam int FRAME_LEN  = 34;
	localparam int REPEAT_LEN = 2;
	localparam int CNT_W      = 6;
	localparam logic [CNT_W-1:0] CNT_MAX        = '1;
	localparam logic [CNT_W-1:0] IDX_FIRST_ADDR = CNT_W'(1);
	localparam logic [CNT_W-1:0] IDX_LAST_ADDR  = CNT_W'(16);
	localparam logic [CNT_W-1:0] IDX_LAST_CMD   = CNT_W'(32);
	localparam logic [CNT_W-1:0] IDX_FRAME_END  = CNT_W'(FRAME_LEN - 1);
	localparam logic [CNT_W-1:0] IDX_REPEAT_END = CNT_W'(REPEAT_LEN - 1);

	// Address filter byte classes
	localparam logic [7:0] ADDR_RSVD_LO  = 8'hF0;
	localparam logic [7:0] ADDR_RSVD_HI  = 8'hFE;
	localparam logic [7:0] ADDR_MCAST_HI = 8'h0F;
	localparam logic [7:0] ADDR_BCAST    = 8'hFF;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam logic [9:0]  MARGIN_RESET  = 10'd200;
	localparam logic [15:0] MCAST_RESET   = 16'd0;
	localparam logic [7:0]  UNICAST_RESET = 8'd0;

	typedef enum logic [1:0] {
		REG_DECODE_MARGIN = 2'd0,
		REG_MCAST_MASK    = 2'd1,
		REG_UCAST_ADDR    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED       = 3'd0,
		ST_REPEAT         = 3'd1,
		ST_PARSE_ERROR    = 3'd2,
		ST_RESERVED       = 3'd3,
		ST_MCAST_REJECTED = 3'd4,
		ST_UCAST_MISMATCH = 3'd5,
		ST_UNKNOWN_LEN    = 3'd6
	} status_t;

	typedef struct packed {
		logic [14:0] mark_duration;
		logic [14:0] space_duration;
		logic        last_symbol;
	} sym_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] frame_addr;
		logic [15:0] frame_command;
	} res_t;

	typedef struct packed {
		logic [9:0]  decode_margin;
		logic [15:0] mcast_mask;
		logic [7:0]  ucast_addr;
	} cfg_t;

	typedef struct packed {
		logic is_lead;
		logic is_repeat;
		logic is_one;
		logic is_zero;
	} sym_class_t;

endpackage

FILE: rtl/necir_cfg_regs.sv
module necir_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [necir_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output necir_pkg::cfg_t               cfg
);

	necir_pkg::cfg_t cfg_q;
	logic            wr_en;
	logic [1:0]      reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decode_margin <= necir_pkg::MARGIN_RESET;
			cfg_q.mcast_mask    <= necir_pkg::MCAST_RESET;
			cfg_q.ucast_addr    <= necir_pkg::UNICAST_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				necir_pkg::REG_DECODE_MARGIN: cfg_q.decode_margin <= pwdata[9:0];
				necir_pkg::REG_MCAST_MASK:    cfg_q.mcast_mask    <= pwdata[15:0];
				necir_pkg::REG_UCAST_ADDR:    cfg_q.ucast_addr    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			necir_pkg::REG_DECODE_MARGIN: prdata = {22'd0, cfg_q.decode_margin};
			necir_pkg::REG_MCAST_MASK:    prdata = {16'd0, cfg_q.mcast_mask};
			necir_pkg::REG_UCAST_ADDR:    prdata = {24'd0, cfg_q.ucast_addr};
			default:                      prdata = 32'd0;
		endcase
	end

endmodule

FILE: rtl/necir_sym_class.sv
module necir_sym_class (
	input  logic [14:0]           mark_duration,
	input  logic [14:0]           space_duration,
	input  logic [9:0]            decode_margin,
	output necir_pkg::sym_class_t cls
);

	// spec - m < d < spec + m, with the lower bound written as d + m > spec
	function automatic logic near_spec(input logic [14:0] d, input logic [15:0] spec,
		input logic [9:0] m);
		logic [15:0] d16;
		logic [15:0] m16;
		d16 = {1'b0, d};
		m16 = {6'd0, m};
		return (d16 < spec + m16) && (d16 + m16 > spec);
	endfunction

	logic mark_lead, mark_rep, mark_bit;
	logic space_lead, space_rep, space_one, space_zero;

	assign mark_lead  = near_spec(mark_duration, necir_pkg::LEAD_MARK, decode_margin);
	assign mark_rep   = near_spec(mark_duration, necir_pkg::REP_MARK, decode_margin);
	assign mark_bit   = near_spec(mark_duration, necir_pkg::BIT_MARK, decode_margin);
	assign space_lead = near_spec(space_duration, necir_pkg::LEAD_SPACE, decode_margin);
	assign space_rep  = near_spec(space_duration, necir_pkg::REP_SPACE, decode_margin);
	assign space_one  = near_spec(space_duration, necir_pkg::ONE_SPACE, decode_margin);
	assign space_zero = near_spec(space_duration, necir_pkg::ZERO_SPACE, decode_margin);

	assign cls.is_lead   = mark_lead && space_lead;
	assign cls.is_repeat = mark_rep && space_rep;
	assign cls.is_one    = mark_bit && space_one;
	assign cls.is_zero   = mark_bit && space_zero;

endmodule

FILE: rtl/necir_addr_filter.sv
module necir_addr_filter (
	input  logic [7:0]         addr_lo,
	input  logic [15:0]        mcast_mask,
	input  logic [7:0]         ucast_addr,
	output necir_pkg::status_t status
);

	always_comb begin
		if (addr_lo inside {[necir_pkg::ADDR_RSVD_LO:necir_pkg::ADDR_RSVD_HI]}) begin
			status = necir_pkg::ST_RESERVED;
		end else if (addr_lo <= necir_pkg::ADDR_MCAST_HI) begin
			status = mcast_mask[addr_lo[3:0]] ? necir_pkg::ST_ACCEPTED
				: necir_pkg::ST_MCAST_REJECTED;
		end else if (addr_lo != necir_pkg::ADDR_BCAST) begin
			status = (addr_lo == ucast_addr) ? necir_pkg::ST_ACCEPTED
				: necir_pkg::ST_UCAST_MISMATCH;
		end else begin
			status = necir_pkg::ST_ACCEPTED;
		end
	end

endmodule

FILE: rtl/nec_ir_frame_decoder_filter.sv
// NEC IR frame decoder with address filter.
// Registers: input reg, then result reg; a final symbol's result is registered when
// that symbol leaves the input reg.
// Throughput: 1 symbol per cycle unless stalled; one compare, shift, filter pass per symbol.
// A non-final symbol keeps moving while a result waits; a final one waits for the result reg.
// Reset (arst_n low, async): burst state cleared, saved frame zero, registers to defaults.
module nec_ir_frame_decoder_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [necir_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// symbol items in
	input  logic                          sym_valid,
	output logic                          sym_ready,
	input  necir_pkg::sym_t               sym,
	// result items out
	output logic                          res_valid,
	input  logic                          res_ready,
	output necir_pkg::res_t               res
);

	necir_pkg::cfg_t       cfg;
	necir_pkg::sym_class_t cls;
	necir_pkg::status_t    filt_status;

	// Stage 1: registered symbol
	logic            s1_valid_q;
	necir_pkg::sym_t sym_s1;
	logic            s1_adv;

	// Burst state
	logic [necir_pkg::CNT_W-1:0] count_q;
	logic [15:0]                 addr_shift_q;
	logic [15:0]                 cmd_shift_q;
	logic                        burst_valid_q;
	logic                        first_rep_q;
	logic [15:0]                 saved_addr_q;
	logic [15:0]                 saved_cmd_q;

	logic [necir_pkg::CNT_W-1:0] count_d;
	logic [15:0]                 addr_shift_d;
	logic [15:0]                 cmd_shift_d;
	logic                        burst_valid_d;
	logic                        first_rep_d;
	logic                        frame_ok;
	necir_pkg::res_t             res_d;

	// Result register
	logic            res_valid_q;
	necir_pkg::res_t res_q;

	necir_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	necir_sym_class u_class (
		.mark_duration  (sym_s1.mark_duration),
		.space_duration (sym_s1.space_duration),
		.decode_margin  (cfg.decode_margin),
		.cls            (cls)
	);

	necir_addr_filter u_filter (
		.addr_lo    (addr_shift_q[7:0]),
		.mcast_mask (cfg.mcast_mask),
		.ucast_addr (cfg.ucast_addr),
		.status     (filt_status)
	);

	// A final symbol needs the result reg free; other symbols only update state.
	assign s1_adv    = s1_valid_q && (!sym_s1.last_symbol || !res_valid_q || res_ready);
	assign sym_ready = !s1_valid_q || s1_adv;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (sym_ready) begin
			s1_valid_q <= sym_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sym_ready && sym_valid) begin
			sym_s1 <= sym;
		end
	end

	// Per-symbol decode. Symbol 0 is the leader (or repeat code), symbols 1..16
	// shift in the address and 17..32 the command, LSB first. A symbol that
	// fits both one and zero (wide margin) counts as a one. The stop symbol
	// is not checked.
	always_comb begin
		burst_valid_d = burst_valid_q;
		first_rep_d   = first_rep_q;
		addr_shift_d  = addr_shift_q;
		cmd_shift_d   = cmd_shift_q;
		if (count_q == '0) begin
			if (!cls.is_lead) begin
				burst_valid_d = 1'b0;
			end
			first_rep_d = cls.is_repeat;
		end else if (count_q <= necir_pkg::IDX_LAST_CMD) begin
			if (!cls.is_one && !cls.is_zero) begin
				burst_valid_d = 1'b0;
			end
			if (count_q <= necir_pkg::IDX_LAST_ADDR) begin
				addr_shift_d = {cls.is_one, addr_shift_q[15:1]};
			end else begin
				cmd_shift_d = {cls.is_one, cmd_shift_q[15:1]};
			end
		end
		count_d = (count_q == necir_pkg::CNT_MAX) ? count_q
			: count_q + necir_pkg::IDX_FIRST_ADDR;
	end

	assign frame_ok = (count_q == necir_pkg::IDX_FRAME_END) && burst_valid_d;

	// Result for a final symbol
	always_comb begin
		res_d.status        = necir_pkg::ST_UNKNOWN_LEN;
		res_d.frame_addr    = 16'd0;
		res_d.frame_command = 16'd0;
		if (count_q == necir_pkg::IDX_FRAME_END) begin
			if (burst_valid_d) begin
				res_d.status        = filt_status;
				res_d.frame_addr    = addr_shift_q;
				res_d.frame_command = cmd_shift_q;
			end else begin
				res_d.status = necir_pkg::ST_PARSE_ERROR;
			end
		end else if (count_q == necir_pkg::IDX_REPEAT_END) begin
			if (first_rep_d) begin
				res_d.status        = necir_pkg::ST_REPEAT;
				res_d.frame_addr    = saved_addr_q;
				res_d.frame_command = saved_cmd_q;
			end else begin
				res_d.status = necir_pkg::ST_PARSE_ERROR;
			end
		end
	end

	// Burst state: the final symbol returns it to idle; the saved frame is
	// taken from any fully parsed frame, even one the filter turns away.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			addr_shift_q  <= 16'd0;
			cmd_shift_q   <= 16'd0;
			burst_valid_q <= 1'b1;
			first_rep_q   <= 1'b0;
			saved_addr_q  <= 16'd0;
			saved_cmd_q   <= 16'd0;
		end else if (s1_adv) begin
			if (sym_s1.last_symbol) begin
				count_q       <= '0;
				addr_shift_q  <= 16'd0;
				cmd_shift_q   <= 16'd0;
				burst_valid_q <= 1'b1;
				first_rep_q   <= 1'b0;
				if (frame_ok) begin
					saved_addr_q <= addr_shift_q;
					saved_cmd_q  <= cmd_shift_q;
				end
			end else begin
				count_q       <= count_d;
				addr_shift_q  <= addr_shift_d;
				cmd_shift_q   <= cmd_shift_d;
				burst_valid_q <= burst_valid_d;
				first_rep_q   <= first_rep_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv && sym_s1.last_symbol) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && sym_s1.last_symbol) begin
			res_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	// Idle burst state is always the cleared one
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (addr_shift_q == 16'd0 && cmd_shift_q == 16'd0
			&& burst_valid_q && !first_rep_q))
		else $error("burst state not cleared at symbol index zero");

	// Input only stalls behind a held final symbol and a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sym_ready |-> (s1_valid_q && sym_s1.last_symbol && res_valid_q && !res_ready))
		else $error("symbol input stalled without cause");

	// Error and unknown-length results carry no frame
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.status == necir_pkg::ST_PARSE_ERROR
			|| res_q.status == necir_pkg::ST_UNKNOWN_LEN))
		|-> (res_q.frame_addr == 16'd0 && res_q.frame_command == 16'd0))
		else $error("error result carries frame data");

	// A final symbol that moves on always yields a result next cycle
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && sym_s1.last_symbol) |=> res_valid_q)
		else $error("final symbol produced no result");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import necir_pkg::*;

	// Clock, reset and every block input start at known values
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic sym_valid = 1'b0;
	logic sym_ready;
	sym_t sym = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	nec_ir_frame_decoder_filter uut (.*);

	always #10 clk = ~clk;

	// Decoder settings as the block should hold them
	logic [9:0] cfg_margin = MARGIN_RESET;
	logic [15:0] cfg_mask = MCAST_RESET;
	logic [7:0] cfg_unicast = UNICAST_RESET;

	// Burst state of the decoder as predicted
	logic [CNT_W-1:0] sym_pos = '0;
	logic [15:0] addr_sr = '0;
	logic [15:0] cmd_sr = '0;
	bit frame_ok = 1'b1;
	bit rep_first = 1'b0;
	logic [15:0] saved_addr = '0;
	logic [15:0] saved_cmd = '0;

	res_t frames_due[$];   // results owed by the block, oldest first
	sym_t burst_syms[$];   // symbols of the burst being sent
	int symbols_sent = 0;
	int mismatches = 0;
	bit tx_stalls = 1'b0;
	bit rx_stalls = 1'b0;
	int stall_left = 0;

	// Directed rows: symbol, plus a hand-written result where one is obvious
	typedef struct {
		sym_t s;
		bit typed;
		res_t want;
	} drill_t;
	drill_t drill[$];

	task automatic note_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Idle lengths: mostly from the short range, now and then from the long one
	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Duration d hits spec s when it lies strictly inside s +/- margin
	function automatic bit in_band(input int d, input int spec);
		int m;
		m = int'(cfg_margin);
		return d < spec + m && d > spec - m;
	endfunction

	// Random duration that lands inside the band around spec; with zero margin it is spec itself
	function automatic logic [14:0] fuzz(input int spec);
		int m;
		m = int'(cfg_margin);
		if (m == 0)
			return 15'(spec);
		return 15'(spec - (m - 1) + int'($urandom_range(0, 2 * (m - 1))));
	endfunction

	// Advances the predicted decoder by one symbol; fires on a burst's last symbol
	function automatic void decode_symbol(input sym_t s, output bit fires, output res_t r);
		int mark;
		int space;
		logic [CNT_W-1:0] pos;
		bit one_ok;
		bit zero_ok;
		logic [7:0] lo;
		mark = int'(s.mark_duration);
		space = int'(s.space_duration);
		pos = sym_pos;
		fires = 1'b0;
		r = '0;
		if (pos == '0) begin
			if (!(in_band(mark, LEAD_MARK) && in_band(space, LEAD_SPACE)))
				frame_ok = 1'b0;
			rep_first = in_band(mark, REP_MARK) && in_band(space, REP_SPACE);
		end else if (pos <= IDX_LAST_CMD) begin
			// overlapping bands resolve to a one
			one_ok = in_band(mark, BIT_MARK) && in_band(space, ONE_SPACE);
			zero_ok = in_band(mark, BIT_MARK) && in_band(space, ZERO_SPACE);
			if (!one_ok && !zero_ok)
				frame_ok = 1'b0;
			if (pos <= IDX_LAST_ADDR)
				addr_sr = {one_ok, addr_sr[15:1]};
			else
				cmd_sr = {one_ok, cmd_sr[15:1]};
		end
		if (sym_pos != CNT_MAX)
			sym_pos++;
		if (!s.last_symbol)
			return;

		fires = 1'b1;
		if (int'(pos) + 1 == FRAME_LEN) begin
			if (!frame_ok) begin
				r.status = ST_PARSE_ERROR;
			end else begin
				// good frame is saved even when the filter drops it
				saved_addr = addr_sr;
				saved_cmd = cmd_sr;
				r.frame_addr = addr_sr;
				r.frame_command = cmd_sr;
				lo = addr_sr[7:0];
				if (lo >= ADDR_RSVD_LO && lo <= ADDR_RSVD_HI)
					r.status = ST_RESERVED;
				else if (lo <= ADDR_MCAST_HI)
					r.status = cfg_mask[lo[3:0]] ? ST_ACCEPTED : ST_MCAST_REJECTED;
				else if (lo != ADDR_BCAST)
					r.status = (lo == cfg_unicast) ? ST_ACCEPTED : ST_UCAST_MISMATCH;
				else
					r.status = ST_ACCEPTED;
			end
		end else if (int'(pos) + 1 == REPEAT_LEN) begin
			if (rep_first) begin
				r.status = ST_REPEAT;
				r.frame_addr = saved_addr;
				r.frame_command = saved_cmd;
			end else begin
				r.status = ST_PARSE_ERROR;
			end
		end else begin
			r.status = ST_UNKNOWN_LEN;
		end
		sym_pos = '0;
		addr_sr = '0;
		cmd_sr = '0;
		frame_ok = 1'b1;
		rep_first = 1'b0;
	endfunction

	function automatic void add_row(input int mark, input int space, input bit last,
			input bit typed = 1'b0, input status_t st = ST_ACCEPTED);
		drill_t row;
		row.s = {15'(mark), 15'(space), last};
		row.typed = typed;
		row.want = {st, 32'h0};
		drill.push_back(row);
	endfunction

	// Fills burst_syms with one burst: mostly real frames, then repeats,
	// odd lengths and plain noise
	function automatic void queue_burst();
		int kind;
		int n;
		int i;
		int k;
		bit b;
		logic [7:0] lo;
		logic [15:0] addr;
		logic [15:0] cmd;
		burst_syms.delete();
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			// address class picked so every filter outcome shows up
			case ($urandom_range(0, 4))
				0: lo = 8'($urandom_range(ADDR_RSVD_LO, ADDR_RSVD_HI));
				1: lo = 8'($urandom_range(0, ADDR_MCAST_HI));
				2: lo = ADDR_BCAST;
				3: lo = cfg_unicast;
				default: lo = 8'($urandom);
			endcase
			addr = {8'($urandom), lo};
			cmd = 16'($urandom);
			burst_syms.push_back({fuzz(LEAD_MARK), fuzz(LEAD_SPACE), 1'b0});
			for (i = 0; i < 32; i++) begin
				b = (i < 16) ? addr[i] : cmd[i - 16];
				burst_syms.push_back({fuzz(BIT_MARK), fuzz(b ? ONE_SPACE : ZERO_SPACE), 1'b0});
			end
			// stop symbol is never checked, so anything goes
			burst_syms.push_back({15'($urandom), 15'($urandom), 1'b1});
			if ($urandom_range(0, 99) < 15) begin
				k = $urandom_range(0, 32);
				burst_syms[k] = {15'($urandom), 15'($urandom), 1'b0};
			end
			if ($urandom_range(0, 99) < 8) begin
				n = $urandom_range(1, 33);
				while (burst_syms.size() > n)
					void'(burst_syms.pop_back());
				burst_syms[n - 1].last_symbol = 1'b1;
			end
		end else if (kind < 72) begin
			if ($urandom_range(0, 99) < 85)
				burst_syms.push_back({fuzz(REP_MARK), fuzz(REP_SPACE), 1'b0});
			else
				burst_syms.push_back({15'($urandom), 15'($urandom), 1'b0});
			burst_syms.push_back({15'($urandom), 15'($urandom), 1'b1});
		end else if (kind < 85) begin
			// some run past the counter's saturation point
			n = $urandom_range(0, 1) ? $urandom_range(64, 72) : $urandom_range(3, 40);
			burst_syms.push_back({fuzz(LEAD_MARK), fuzz(LEAD_SPACE), 1'(n == 1)});
			for (i = 1; i < n; i++) begin
				if ($urandom_range(0, 99) < 90)
					burst_syms.push_back({fuzz(BIT_MARK),
						fuzz($urandom_range(0, 1) ? ONE_SPACE : ZERO_SPACE), 1'(i == n - 1)});
				else
					burst_syms.push_back({15'($urandom), 15'($urandom), 1'(i == n - 1)});
			end
		end else begin
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++)
				burst_syms.push_back({15'($urandom), 15'($urandom), 1'(i == n - 1)});
		end
	endfunction

	// One symbol item: holds valid until taken, then predicts and maybe idles
	task automatic send_sym(input sym_t s, input bit typed, input res_t want);
		bit fires;
		res_t r;
		int gap;
		sym <= s;
		sym_valid <= 1'b1;
		do @(posedge clk); while (!sym_ready);
		decode_symbol(s, fires, r);
		symbols_sent++;
		if (fires)
			frames_due.push_back(typed ? want : r);
		gap = (tx_stalls && $urandom_range(0, 99) < 30) ? gap_len() : 0;
		if (gap > 0) begin
			sym_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Setup cycle, then access cycle; the register takes the data while pready is high
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DECODE_MARGIN: cfg_margin = val[9:0];
			REG_MCAST_MASK: cfg_mask = val[15:0];
			REG_UCAST_ADDR: cfg_unicast = val[7:0];
			default: ;
		endcase
	endtask

	// Drop valid and let every owed result drain, plus the block's latency,
	// so a register write never lands on a symbol still in flight
	task automatic settle();
		int k;
		sym_valid <= 1'b0;
		for (k = 0; k < 20000 && frames_due.size() != 0; k++)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Settings per phase: the first two pin the extremes, the rest roll dice
	task automatic run_phase(input int p);
		logic [9:0] margin;
		logic [15:0] mask;
		logic [7:0] uni;
		int bursts;
		int i;
		int j;
		settle();
		if (p == 0) begin
			margin = 10'd559;
			mask = 16'hFFFF;
			uni = 8'hFF;
		end else if (p == 1) begin
			margin = 10'd0;   // nothing can match: every frame fails to parse
			mask = 16'h0;
			uni = 8'h0;
		end else begin
			case ($urandom_range(0, 5))
				0: margin = 10'd559;
				1: margin = 10'd200;
				2: margin = 10'd1;
				default: margin = 10'($urandom_range(1, 559));
			endcase
			case ($urandom_range(0, 3))
				0: mask = 16'h0;
				1: mask = 16'hFFFF;
				default: mask = 16'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0: uni = 8'h0;
				1: uni = 8'hFF;
				2: uni = 8'($urandom_range(16, 239));
				default: uni = 8'($urandom);
			endcase
		end
		write_reg(REG_DECODE_MARGIN, 32'(margin));
		write_reg(REG_MCAST_MASK, 32'(mask));
		write_reg(REG_UCAST_ADDR, 32'(uni));
		tx_stalls = $urandom_range(0, 3) != 0;
		rx_stalls = $urandom_range(0, 3) != 0;
		bursts = (p == 1) ? 2 : $urandom_range(2, 5);
		for (i = 0; i < bursts; i++) begin
			queue_burst();
			for (j = 0; j < burst_syms.size(); j++)
				send_sym(burst_syms[j], 1'b0, '0);
		end
	endtask

	// Result side: check at the edge, then decide ready for the next one
	always @(posedge clk) begin : rx_side
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (frames_due.size() == 0) begin
				note_mismatch($sformatf("unowed result st=%0d a=%h c=%h",
					res.status, res.frame_addr, res.frame_command));
			end else begin
				want = frames_due.pop_front();
				if (res.status !== want.status)
					note_mismatch($sformatf("result code got %0d want %0d",
						res.status, want.status));
				if (res.frame_addr !== want.frame_addr)
					note_mismatch($sformatf("frame_addr got %h want %h",
						res.frame_addr, want.frame_addr));
				if (res.frame_command !== want.frame_command)
					note_mismatch($sformatf("frame_command got %h want %h",
						res.frame_command, want.frame_command));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if (rx_stalls && $urandom_range(0, 99) < 30) begin
			stall_left = gap_len() - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int p;
		int i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at reset settings (margin 200, nothing saved yet)
		add_row(9000, 2250, 1'b0);                          // repeat code
		add_row(560, 560, 1'b1, 1'b1, ST_REPEAT);           // saved frame is still zero
		add_row(0, 0, 1'b1, 1'b1, ST_UNKNOWN_LEN);          // one-symbol burst
		add_row(32767, 32767, 1'b0);
		add_row(32767, 32767, 1'b1, 1'b1, ST_PARSE_ERROR);  // two symbols, no repeat code
		add_row(9000, 4500, 1'b0);                          // leader is not a repeat
		add_row(560, 1690, 1'b1, 1'b1, ST_PARSE_ERROR);
		add_row(8801, 2449, 1'b0);                          // just inside both bands
		add_row(32767, 0, 1'b1, 1'b1, ST_REPEAT);           // second symbol unchecked
		add_row(9200, 2250, 1'b0);                          // on the band edge: miss
		add_row(560, 560, 1'b1, 1'b1, ST_PARSE_ERROR);
		add_row(9000, 4500, 1'b0);
		add_row(560, 560, 1'b0);
		add_row(0, 32767, 1'b1, 1'b1, ST_UNKNOWN_LEN);      // three symbols
		add_row(16383, 16384, 1'b1, 1'b1, ST_UNKNOWN_LEN);
		add_row(8799, 4301, 1'b0);                          // band edges on the leader
		add_row(560, 560, 1'b1, 1'b1, ST_PARSE_ERROR);
		tx_stalls = 1'b1;
		rx_stalls = 1'b1;
		for (i = 0; i < drill.size(); i++)
			send_sym(drill[i].s, drill[i].typed, drill[i].want);

		// Random phases until enough symbols have gone through
		p = 0;
		while (symbols_sent < 650) begin
			run_phase(p);
			p++;
		end

		settle();
		if (frames_due.size() != 0)
			note_mismatch($sformatf("%0d results never came out", frames_due.size()));
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin : watchdog
		#20_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
